// ===== rtl/core/mrmd_pkg.sv =====
package mrmd_pkg;

	// Default fraction bits of the ramp and mix arithmetic
	localparam int FRAC_BITS_DEF = 8;

	// Wheel count and divider shape
	localparam int NUM_WHEELS   = 4;
	localparam int WHEEL_IDX_W  = $clog2(NUM_WHEELS);
	localparam int QUOT_W       = 16;
	localparam int DIV_BITS_PER = 2;
	localparam int DIV_CYCLES   = QUOT_W / DIV_BITS_PER;
	localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_RPM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_STEP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_LIMIT   = 3'd6;

	// Drive modes; the unused code behaves as halt
	localparam logic [1:0] MODE_SPEED  = 2'd0;
	localparam logic [1:0] MODE_HALT   = 2'd1;
	localparam logic [1:0] MODE_DIRECT = 2'd2;

	typedef struct packed {
		logic [1:0]  drive_mode;
		logic        ramp_enable;
		logic [14:0] launch_rpm;
		logic [22:0] launch_step;
		logic [22:0] normal_step;
		logic [22:0] brake_step;
		logic [14:0] rpm_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] cmd_x;
		logic signed [15:0] cmd_y;
		logic signed [15:0] cmd_z;
	} req_t;

	typedef struct packed {
		logic signed [15:0] wheel_lf;
		logic signed [15:0] wheel_rf;
		logic signed [15:0] wheel_rb;
		logic signed [15:0] wheel_lb;
		logic               was_scaled;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAMP,
		ST_MIX,
		ST_PEAK,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                   load_in;
		logic                   do_ramp;
		logic                   do_mix;
		logic                   do_peak;
		logic                   do_mul;
		logic                   do_div;
		logic                   div_last;
		logic                   load_out;
		logic [WHEEL_IDX_W-1:0] wheel_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
	} ctrl_stat_t;

endpackage

// ===== rtl/core/mecanum_ramp_mix_desaturate_core.sv =====
// Each item passes the ramp, mix and peak states and, when the wheels need scaling, a
// multiply and a divide for each of the four wheels in turn on the shared 2-bit-per-cycle
// divider. One item at a time: the next is accepted once the result is in the output register.
// Reset (arst_n low, asynchronous): ramp state is zero, registers take their reset
// values (halt mode, limit 32767), and no result is pending.
module mecanum_ramp_mix_desaturate_core #(
	parameter int FRAC_BITS = mrmd_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  mrmd_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output mrmd_pkg::rsp_t                   rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mrmd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mrmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mrmd_pkg::*;

	cfg_t       cfg_q;
	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_mode  <= MODE_HALT;
			cfg_q.ramp_enable <= 1'b0;
			cfg_q.launch_rpm  <= '0;
			cfg_q.launch_step <= '0;
			cfg_q.normal_step <= '0;
			cfg_q.brake_step  <= '0;
			cfg_q.rpm_limit   <= 15'h7fff;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DRIVE_MODE:  cfg_q.drive_mode  <= cfg_data[1:0];
				REG_RAMP_ENABLE: cfg_q.ramp_enable <= cfg_data[0];
				REG_LAUNCH_RPM:  cfg_q.launch_rpm  <= cfg_data[14:0];
				REG_LAUNCH_STEP: cfg_q.launch_step <= cfg_data[22:0];
				REG_NORMAL_STEP: cfg_q.normal_step <= cfg_data[22:0];
				REG_BRAKE_STEP:  cfg_q.brake_step  <= cfg_data[22:0];
				REG_RPM_LIMIT:   cfg_q.rpm_limit   <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	mrmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mrmd_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

`ifndef NO_ASSERTIONS
	logic signed [16:0] lim_s;
	assign lim_s = $signed({2'b00, cfg_q.rpm_limit});

	// One item at a time: no second item right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while busy");

	// Scaled wheels never exceed the limit
	a_scaled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.was_scaled |->
			rsp.wheel_lf <= lim_s && rsp.wheel_lf >= -lim_s &&
			rsp.wheel_rf <= lim_s && rsp.wheel_rf >= -lim_s &&
			rsp.wheel_rb <= lim_s && rsp.wheel_rb >= -lim_s &&
			rsp.wheel_lb <= lim_s && rsp.wheel_lb >= -lim_s)
		else $error("scaled wheel above limit");

	// Unscaled wheels stay strictly below the limit
	a_unscaled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.was_scaled |->
			rsp.wheel_lf < lim_s && rsp.wheel_lf > -lim_s &&
			rsp.wheel_rf < lim_s && rsp.wheel_rf > -lim_s &&
			rsp.wheel_rb < lim_s && rsp.wheel_rb > -lim_s &&
			rsp.wheel_lb < lim_s && rsp.wheel_lb > -lim_s)
		else $error("unscaled wheel at or above limit");
`endif

endmodule

// ===== rtl/core/mrmd_ctrl.sv =====
module mrmd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  mrmd_pkg::ctrl_stat_t stat,
	output mrmd_pkg::ctrl_cmd_t  cmd
);
	import mrmd_pkg::*;

	localparam logic [DIV_CNT_W-1:0]   DIV_LAST   = DIV_CNT_W'(DIV_CYCLES - 1);
	localparam logic [WHEEL_IDX_W-1:0] WHEEL_LAST = WHEEL_IDX_W'(NUM_WHEELS - 1);

	state_t                 state_q, state_d;
	logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
	logic [WHEEL_IDX_W-1:0] wheel_q, wheel_d;
	logic                   rsp_valid_q;

	// State, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			wheel_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			div_cnt_q <= div_cnt_d;
			wheel_q   <= wheel_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	// Sequence one item through ramp, mix, peak and the per-wheel divide
	always_comb begin
		state_d       = state_q;
		div_cnt_d     = div_cnt_q;
		wheel_d       = wheel_q;
		req_ready     = 1'b0;
		cmd           = '0;
		cmd.wheel_sel = wheel_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_RAMP;
				end
			end
			ST_RAMP: begin
				cmd.do_ramp = 1'b1;
				state_d     = ST_MIX;
			end
			ST_MIX: begin
				cmd.do_mix = 1'b1;
				state_d    = ST_PEAK;
			end
			ST_PEAK: begin
				cmd.do_peak = 1'b1;
				wheel_d     = '0;
				state_d     = stat.need_div ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				cmd.do_mul = 1'b1;
				div_cnt_d  = '0;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.do_div = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					cmd.div_last = 1'b1;
					if (wheel_q == WHEEL_LAST) begin
						state_d = ST_DONE;
					end else begin
						wheel_d = wheel_q + 1'b1;
						state_d = ST_MUL;
					end
				end else begin
					div_cnt_d = div_cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/mrmd_datapath.sv =====
module mrmd_datapath #(
	parameter int FRAC_BITS = mrmd_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrmd_pkg::cfg_t       cfg,
	input  mrmd_pkg::req_t       req,
	input  mrmd_pkg::ctrl_cmd_t  cmd,
	output mrmd_pkg::ctrl_stat_t stat,
	output mrmd_pkg::rsp_t       rsp
);
	import mrmd_pkg::*;

	// Ramp values, mixed sums and slew working width
	localparam int RW = 16 + FRAC_BITS;
	localparam int MW = RW + 2;
	localparam int SW = (RW + 2 > 25) ? RW + 2 : 25;

	req_t                  req_q;
	logic signed [RW-1:0]  ramp_x_q, ramp_y_q;
	logic signed [RW-1:0]  x_q, y_q, z_q;
	logic signed [17:0]    wheel_q [NUM_WHEELS];
	logic [16:0]           peak_q;
	logic                  scaled_q;
	logic [16:0]           rem_q;
	logic [QUOT_W-1:0]     num_q;
	logic [QUOT_W-1:0]     quot_q;
	rsp_t                  rsp_q;

	logic signed [RW-1:0]  cx, cy, cz;
	logic signed [RW-1:0]  nx, ny, nz, rx, ry;
	logic signed [MW-1:0]  sum_lf, sum_rf, sum_rb, sum_lb;
	logic [16:0]           mag_w [NUM_WHEELS];
	logic [16:0]           peak_a, peak_b, peak_c;
	logic [16:0]           lim17;
	logic [31:0]           prod_c;
	logic [16:0]           rem_d;
	logic [QUOT_W-1:0]     num_d, quot_d;
	logic signed [17:0]    quot_s;

	// Move one ramp value toward its command by at most one step
	function automatic logic signed [RW-1:0] slew(
		input logic signed [RW-1:0] last,
		input logic signed [RW-1:0] target
	);
		logic signed [SW-1:0] l, c, d, m_l, m_c, m_d, st, lim_fix;
		l       = SW'(last);
		c       = SW'(target);
		d       = c - l;
		m_l     = (l < 0) ? -l : l;
		m_c     = (c < 0) ? -c : c;
		m_d     = (d < 0) ? -d : d;
		lim_fix = SW'(cfg.launch_rpm) <<< FRAC_BITS;
		if (m_c > m_l) begin
			st = (m_c <= lim_fix) ? SW'(cfg.launch_step) : SW'(cfg.normal_step);
		end else begin
			st = SW'(cfg.brake_step);
		end
		if (m_d >= st) begin
			slew = RW'((d >= 0) ? l + st : l - st);
		end else begin
			slew = target;
		end
	endfunction

	// Truncate a fixed-point sum toward zero to whole rpm
	function automatic logic signed [17:0] to_rpm(input logic signed [MW-1:0] v);
		logic signed [MW-1:0] m;
		logic [MW-1:0]        mu;
		logic signed [17:0]   r;
		m      = (v < 0) ? -v : v;
		mu     = m;
		r      = 18'(mu >> FRAC_BITS);
		to_rpm = (v < 0) ? -r : r;
	endfunction

	function automatic logic [16:0] mag17(input logic signed [17:0] w);
		logic signed [17:0] m;
		m     = (w < 0) ? -w : w;
		mag17 = m[16:0];
	endfunction

	// Commands in fixed point
	assign cx = RW'(req_q.cmd_x) <<< FRAC_BITS;
	assign cy = RW'(req_q.cmd_y) <<< FRAC_BITS;
	assign cz = RW'(req_q.cmd_z) <<< FRAC_BITS;

	// Pick chassis speeds by drive mode
	always_comb begin
		rx = cfg.ramp_enable ? slew(ramp_x_q, cx) : cx;
		ry = cfg.ramp_enable ? slew(ramp_y_q, cy) : cy;
		case (cfg.drive_mode)
			MODE_SPEED: begin
				nx = rx;
				ny = ry;
				nz = cz;
			end
			MODE_DIRECT: begin
				nx = cx;
				ny = cy;
				nz = cz;
			end
			default: begin
				nx = '0;
				ny = '0;
				nz = '0;
			end
		endcase
	end

	// Mecanum mix
	assign sum_lf = MW'(x_q) + MW'(y_q) - MW'(z_q);
	assign sum_rf = MW'(y_q) - MW'(x_q) + MW'(z_q);
	assign sum_rb = MW'(x_q) + MW'(y_q) + MW'(z_q);
	assign sum_lb = MW'(y_q) - MW'(x_q) - MW'(z_q);

	// Peak wheel magnitude against the limit
	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			mag_w[i] = mag17(wheel_q[i]);
		end
		peak_a        = (mag_w[0] > mag_w[1]) ? mag_w[0] : mag_w[1];
		peak_b        = (mag_w[2] > mag_w[3]) ? mag_w[2] : mag_w[3];
		peak_c        = (peak_a > peak_b) ? peak_a : peak_b;
		lim17         = {2'b00, cfg.rpm_limit};
		stat.need_div = (peak_c >= lim17) && (peak_c != '0);
	end

	// Scale numerator of the selected wheel
	assign prod_c = mag_w[cmd.wheel_sel] * cfg.rpm_limit;

	// Two restoring divide steps per cycle
	always_comb begin
		logic [17:0] t;
		rem_d  = rem_q;
		num_d  = num_q;
		quot_d = quot_q;
		for (int i = 0; i < DIV_BITS_PER; i++) begin
			t     = {rem_d, num_d[QUOT_W-1]};
			num_d = num_d << 1;
			if (t >= {1'b0, peak_q}) begin
				t      = t - {1'b0, peak_q};
				quot_d = {quot_d[QUOT_W-2:0], 1'b1};
			end else begin
				quot_d = {quot_d[QUOT_W-2:0], 1'b0};
			end
			rem_d = t[16:0];
		end
		quot_s = $signed({2'b00, quot_d});
	end

	// Ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_x_q <= '0;
			ramp_y_q <= '0;
		end else if (cmd.do_ramp && cfg.drive_mode == MODE_SPEED) begin
			ramp_x_q <= rx;
			ramp_y_q <= ry;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= req;
		end
		if (cmd.do_ramp) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
		if (cmd.do_mix) begin
			wheel_q[0] <= to_rpm(sum_lf);
			wheel_q[1] <= to_rpm(sum_rf);
			wheel_q[2] <= to_rpm(sum_rb);
			wheel_q[3] <= to_rpm(sum_lb);
		end
		if (cmd.do_peak) begin
			peak_q   <= peak_c;
			scaled_q <= peak_c >= lim17;
		end
		if (cmd.do_mul) begin
			rem_q  <= {1'b0, prod_c[31:QUOT_W]};
			num_q  <= prod_c[QUOT_W-1:0];
			quot_q <= '0;
		end
		if (cmd.do_div) begin
			rem_q  <= rem_d;
			num_q  <= num_d;
			quot_q <= quot_d;
		end
		if (cmd.div_last) begin
			wheel_q[cmd.wheel_sel] <= wheel_q[cmd.wheel_sel][17] ? -quot_s : quot_s;
		end
		if (cmd.load_out) begin
			rsp_q.wheel_lf   <= wheel_q[0][15:0];
			rsp_q.wheel_rf   <= wheel_q[1][15:0];
			rsp_q.wheel_rb   <= wheel_q[2][15:0];
			rsp_q.wheel_lb   <= wheel_q[3][15:0];
			rsp_q.was_scaled <= scaled_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== verif/mecanum_ramp_mix_desaturate_core_test.sv =====
module mecanum_ramp_mix_desaturate_core_test;
	import mrmd_pkg::*;

	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int RAMP_W         = 16 + FRAC;
	localparam int PERIOD         = 12;
	localparam int TIMEOUT_CYCLES = 600000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 104;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 45;

	// Codes with no name in the package
	localparam logic [1:0]           MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [22:0]          STEP_MAX   = 23'h7FFFFF;

	// Predict wheel rpms from chassis commands and check them in order
	class drive_tracker;
		cfg_t regs;
		logic signed [RAMP_W-1:0] ramp_x;
		logic signed [RAMP_W-1:0] ramp_y;
		rsp_t pending_wheels[$];
		int commands;
		int results;
		int scaled;
		int errors;

		function new();
			regs = '0;
			regs.drive_mode = MODE_HALT;
			regs.rpm_limit = 15'h7FFF;
			ramp_x = '0;
			ramp_y = '0;
			commands = 0;
			results = 0;
			scaled = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DRIVE_MODE:  regs.drive_mode = data[1:0];
				REG_RAMP_ENABLE: regs.ramp_enable = data[0];
				REG_LAUNCH_RPM:  regs.launch_rpm = data[14:0];
				REG_LAUNCH_STEP: regs.launch_step = data[22:0];
				REG_NORMAL_STEP: regs.normal_step = data[22:0];
				REG_BRAKE_STEP:  regs.brake_step = data[22:0];
				REG_RPM_LIMIT:   regs.rpm_limit = data[14:0];
				default: ;
			endcase
		endfunction

		function longint magnitude(longint v);
			return v < 0 ? -v : v;
		endfunction

		// Move one ramp value toward its command by at most one step
		function longint slew_toward(longint last, longint target);
			longint step;
			longint diff;
			diff = target - last;
			if (magnitude(target) > magnitude(last)) begin
				if (magnitude(target) <= (longint'(regs.launch_rpm) << FRAC))
					step = longint'(regs.launch_step);
				else
					step = longint'(regs.normal_step);
			end else begin
				step = longint'(regs.brake_step);
			end
			if (magnitude(diff) >= step)
				return diff >= 0 ? last + step : last - step;
			return target;
		endfunction

		// Drop the fraction bits, truncating toward zero
		function longint whole_rpm(longint v);
			longint m;
			m = magnitude(v) >> FRAC;
			return v < 0 ? -m : m;
		endfunction

		function rsp_t wheel_speeds_for(req_t c);
			longint unit_rpm;
			longint x;
			longint y;
			longint z;
			longint w[4];
			longint peak;
			longint lim;
			rsp_t r;
			unit_rpm = longint'(1) << FRAC;
			case (regs.drive_mode)
				MODE_SPEED: begin
					if (regs.ramp_enable) begin
						ramp_x = RAMP_W'(slew_toward(longint'(ramp_x), c.cmd_x * unit_rpm));
						ramp_y = RAMP_W'(slew_toward(longint'(ramp_y), c.cmd_y * unit_rpm));
					end else begin
						ramp_x = RAMP_W'(c.cmd_x * unit_rpm);
						ramp_y = RAMP_W'(c.cmd_y * unit_rpm);
					end
					x = longint'(ramp_x);
					y = longint'(ramp_y);
					z = c.cmd_z * unit_rpm;
				end
				MODE_DIRECT: begin
					x = c.cmd_x * unit_rpm;
					y = c.cmd_y * unit_rpm;
					z = c.cmd_z * unit_rpm;
				end
				default: begin
					x = 0;
					y = 0;
					z = 0;
				end
			endcase

			// Mix into the four wheels
			w[0] = whole_rpm(x + y - z);
			w[1] = whole_rpm(-x + y + z);
			w[2] = whole_rpm(x + y + z);
			w[3] = whole_rpm(-x + y - z);

			// Scale all wheels down when the peak reaches the limit
			peak = 0;
			foreach (w[k])
				if (magnitude(w[k]) > peak)
					peak = magnitude(w[k]);
			lim = longint'(regs.rpm_limit);
			r.was_scaled = peak >= lim;
			if (r.was_scaled && peak != 0)
				foreach (w[k])
					w[k] = w[k] < 0 ? -(magnitude(w[k]) * lim / peak)
						: magnitude(w[k]) * lim / peak;
			r.wheel_lf = 16'(w[0]);
			r.wheel_rf = 16'(w[1]);
			r.wheel_rb = 16'(w[2]);
			r.wheel_lb = 16'(w[3]);
			return r;
		endfunction

		function void note_cmd(req_t c);
			pending_wheels.push_back(wheel_speeds_for(c));
			commands++;
		endfunction

		function void check_wheels(rsp_t got);
			rsp_t want;
			if (pending_wheels.size() == 0) begin
				$error("wheel item with no command waiting: %p", got);
				errors++;
				return;
			end
			want = pending_wheels.pop_front();
			results++;
			if (want.was_scaled)
				scaled++;
			if (got.wheel_lf !== want.wheel_lf) begin
				$error("wheel_lf expected %0d got %0d", want.wheel_lf, got.wheel_lf);
				errors++;
			end
			if (got.wheel_rf !== want.wheel_rf) begin
				$error("wheel_rf expected %0d got %0d", want.wheel_rf, got.wheel_rf);
				errors++;
			end
			if (got.wheel_rb !== want.wheel_rb) begin
				$error("wheel_rb expected %0d got %0d", want.wheel_rb, got.wheel_rb);
				errors++;
			end
			if (got.wheel_lb !== want.wheel_lb) begin
				$error("wheel_lb expected %0d got %0d", want.wheel_lb, got.wheel_lb);
				errors++;
			end
			if (got.was_scaled !== want.was_scaled) begin
				$error("was_scaled expected %0d got %0d", want.was_scaled, got.was_scaled);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit steady = 1'b0;
	bit want_hold = 1'b0;
	int settings_used = 0;
	drive_tracker tracker = new();

	mecanum_ramp_mix_desaturate_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #(PERIOD / 2) clk = ~clk;
	end

	// Give up if the block stops making progress
	initial begin
		#(PERIOD * TIMEOUT_CYCLES);
		$display("[mecanum_ramp_mix_desaturate_core] ERROR");
		$finish;
	end

	// Take wheel items; stall at random, or hold off for a long stretch on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				tracker.check_wheels(rsp);
			if (want_hold) begin
				want_hold = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= steady || $urandom_range(99) >= 6;
			end
		end
	end

	// Hold a register write until taken; the caller lowers valid after the batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_reg(idx, data);
	endtask

	task automatic load_setting(input cfg_t s);
		write_reg(REG_DRIVE_MODE, CFG_DATA_W'(s.drive_mode));
		write_reg(REG_RAMP_ENABLE, CFG_DATA_W'(s.ramp_enable));
		write_reg(REG_LAUNCH_RPM, CFG_DATA_W'(s.launch_rpm));
		write_reg(REG_LAUNCH_STEP, CFG_DATA_W'(s.launch_step));
		write_reg(REG_NORMAL_STEP, CFG_DATA_W'(s.normal_step));
		write_reg(REG_BRAKE_STEP, CFG_DATA_W'(s.brake_step));
		write_reg(REG_RPM_LIMIT, CFG_DATA_W'(s.rpm_limit));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Offer one command item, idling first now and then, and hold it until taken
	task automatic send_cmd(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] z);
		req_t c;
		c.cmd_x = x;
		c.cmd_y = y;
		c.cmd_z = z;
		while (!steady && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= c;
		do
			@(posedge clk);
		while (!req_ready);
		tracker.note_cmd(c);
	endtask

	// Stop offering and wait for every outstanding wheel item
	task automatic drain();
		req_valid <= 1'b0;
		while (tracker.pending_wheels.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_speed();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3, 4: return 16'($urandom);
			default: return 16'($urandom_range(6000)) - 16'sd3000;
		endcase
	endfunction

	function automatic logic [22:0] pick_step();
		case ($urandom_range(7))
			0: return '0;
			1: return STEP_MAX;
			2: return 23'($urandom_range(1, 255));
			7: return 23'($urandom);
			default: return 23'($urandom_range(1, 3000) << FRAC | $urandom_range(255));
		endcase
	endfunction

	// Favor speed mode with the ramp on; first two phases pin the launch extremes
	function automatic cfg_t pick_setting(int phase);
		cfg_t s;
		int roll;
		roll = $urandom_range(19);
		if (roll < 14 || phase < 2)
			s.drive_mode = MODE_SPEED;
		else if (roll < 17)
			s.drive_mode = MODE_DIRECT;
		else if (roll < 19)
			s.drive_mode = MODE_HALT;
		else
			s.drive_mode = MODE_SPARE;
		s.ramp_enable = phase < 2 || $urandom_range(6) != 0;
		case ($urandom_range(3))
			0: s.launch_rpm = '0;
			1: s.launch_rpm = 15'h7FFF;
			2: s.launch_rpm = 15'($urandom_range(5000));
			default: s.launch_rpm = 15'($urandom);
		endcase
		s.launch_step = pick_step();
		s.normal_step = pick_step();
		s.brake_step = pick_step();
		case ($urandom_range(5))
			0: s.rpm_limit = 15'h7FFF;
			1: s.rpm_limit = 15'd1;
			2: s.rpm_limit = 15'($urandom);
			default: s.rpm_limit = 15'($urandom_range(2000, 32767));
		endcase
		if (phase == 0) begin
			s.launch_rpm = 15'h7FFF;
			s.launch_step = STEP_MAX;
			s.normal_step = STEP_MAX;
			s.brake_step = STEP_MAX;
		end else if (phase == 1) begin
			s.launch_rpm = '0;
		end
		return s;
	endfunction

	initial begin
		cfg_t setting;
		logic signed [15:0] aim_x;
		logic signed [15:0] aim_y;
		int held;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Halt after reset, then the spare mode code, which halts as well
		send_cmd(16'sh7FFF, 16'sh8000, 16'sd12345);
		drain();
		setting = tracker.regs;
		setting.drive_mode = MODE_SPARE;
		write_reg(REG_UNUSED, 23'($urandom));
		load_setting(setting);
		send_cmd(16'sd1000, 16'sd2000, 16'sd3000);
		drain();

		// Direct mode: field extremes and scaling at and above the limit
		setting.drive_mode = MODE_DIRECT;
		load_setting(setting);
		send_cmd(16'sd0, 16'sd0, 16'sd0);
		send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
		send_cmd(16'sh8000, 16'sd0, 16'sd0);
		send_cmd(16'sd100, -16'sd200, 16'sd300);
		send_cmd(16'sh7FFF, 16'sd0, 16'sd0);
		send_cmd(16'sd0, 16'sd0, 16'sh8000);
		drain();

		// Limit of zero scales everything to zero, even a zero peak
		setting.rpm_limit = '0;
		load_setting(setting);
		send_cmd(16'sd5, 16'sd6, 16'sd7);
		send_cmd(16'sd0, 16'sd0, 16'sd0);
		drain();
		setting.rpm_limit = 15'd1;
		load_setting(setting);
		send_cmd(16'sd3, -16'sd2, 16'sd1);
		drain();

		// Speed mode with the ramp off loads the ramp with the command
		setting.rpm_limit = 15'h7FFF;
		setting.drive_mode = MODE_SPEED;
		load_setting(setting);
		send_cmd(16'sd1234, -16'sd4321, 16'sd77);
		send_cmd(16'sh8000, 16'sh7FFF, 16'sd0);
		send_cmd(16'sd0, 16'sd0, 16'sd0);
		drain();

		// Ramp on: launch, normal and brake steps, and a sign change while braking
		setting.ramp_enable = 1'b1;
		setting.launch_rpm = 15'd1000;
		setting.launch_step = 23'(50 << FRAC);
		setting.normal_step = 23'(10 << FRAC);
		setting.brake_step = 23'(100 << FRAC);
		load_setting(setting);
		repeat (3) send_cmd(16'sd800, -16'sd800, 16'sd5);
		repeat (3) send_cmd(16'sd5000, 16'sd5000, 16'sd0);
		repeat (2) send_cmd(16'sd0, 16'sd0, 16'sd0);
		send_cmd(-16'sd300, 16'sd300, 16'sd0);
		drain();

		// Random phases: held targets let the ramp settle, with noise mixed in
		for (int p = 0; p < PHASES; p++) begin
			setting = pick_setting(p);
			load_setting(setting);
			steady = p == 2;
			if (p == 3)
				want_hold = 1'b1;
			held = 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (held == 0) begin
					aim_x = pick_speed();
					aim_y = pick_speed();
					held = $urandom_range(1, 12);
				end
				held--;
				if ($urandom_range(6) == 0)
					send_cmd(16'($urandom), 16'($urandom), 16'($urandom));
				else
					send_cmd(aim_x, aim_y, $urandom_range(3) == 0 ? pick_speed()
						: 16'($urandom_range(800)) - 16'sd400);
			end
			drain();
		end

		// Let any stray item show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Drove %0d commands under %0d register settings.",
			tracker.commands, settings_used);
		$display("Checked %0d wheel items, %0d of them desaturated.",
			tracker.results, tracker.scaled);
		if (tracker.errors == 0 && tracker.pending_wheels.size() == 0)
			$display("[mecanum_ramp_mix_desaturate_core] OK");
		else
			$display("[mecanum_ramp_mix_desaturate_core] ERROR");
		$finish;
	end

endmodule
